### design/euc_pkg.sv
package euc_pkg;

   localparam int COUNTER_BITS   = 64;
   localparam int LENGTH_BITS    = 16;
   localparam int WIRE_BITS      = 16;
   localparam int NUM_COUNTERS   = 8;
   localparam int CIDX_BITS      = $clog2(NUM_COUNTERS);
   // pending byte count of one counter covers one full drain round
   localparam int ACC_BITS       = WIRE_BITS + CIDX_BITS;
   localparam int EXTRA_BITS     = ACC_BITS + 1;
   localparam int FIFO_DEPTH     = 8;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int FIFO_LVL_BITS  = FIFO_PTR_BITS + 1;
   localparam int FIFO_SUM_BITS  = FIFO_LVL_BITS + 1;

   localparam logic [15:0] TYPE_ARP    = 16'h0806;
   localparam logic [15:0] TYPE_IPV4   = 16'h0800;
   localparam logic [7:0]  PROTO_UDP   = 8'd17;
   localparam logic [7:0]  IP_VER_IHL  = 8'h45;
   localparam logic [15:0] UDP_HDR_LEN = 16'd8;

   localparam logic [LENGTH_BITS-1:0] POS_TYPE_HI = LENGTH_BITS'(12);
   localparam logic [LENGTH_BITS-1:0] POS_TYPE_LO = LENGTH_BITS'(13);
   localparam logic [LENGTH_BITS-1:0] POS_IP      = LENGTH_BITS'(14);
   localparam logic [LENGTH_BITS-1:0] POS_PROTO   = LENGTH_BITS'(23);
   localparam logic [LENGTH_BITS-1:0] POS_ULEN_HI = LENGTH_BITS'(38);
   localparam logic [LENGTH_BITS-1:0] POS_ULEN_LO = LENGTH_BITS'(39);
   localparam logic [LENGTH_BITS-1:0] POS_PAYLOAD = LENGTH_BITS'(42);
   localparam logic [LENGTH_BITS-1:0] LEN_MAX     = '1;

   typedef enum logic {
      CMD_FRAME = 1'b0,
      CMD_READ  = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_VERDICT = 2'd1,
      KIND_COUNTER = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      VERD_TRUNC   = 3'd0,
      VERD_UDP     = 3'd1,
      VERD_IPOTHER = 3'd2,
      VERD_ARP     = 3'd3,
      VERD_UNKNOWN = 3'd4
   } verdict_type;

   typedef enum logic [CIDX_BITS-1:0] {
      CNT_TOTAL   = 3'd0,
      CNT_TRUNC   = 3'd1,
      CNT_ARP     = 3'd2,
      CNT_IPV4    = 3'd3,
      CNT_UDP     = 3'd4,
      CNT_IPOTHER = 3'd5,
      CNT_UNKNOWN = 3'd6,
      CNT_BYTES   = 3'd7
   } cnt_idx_type;

   typedef struct packed {
      logic        command;
      logic [7:0]  frame_byte;
      logic        last_byte;
      logic        truncated;
      logic [15:0] wire_length;
      logic [2:0]  counter_index;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  payload_byte;
      logic [2:0]  verdict;
      logic [15:0] payload_length;
      logic [63:0] counter_value;
      logic        final_res;
   } rsp_type;

   typedef struct packed {
      logic [NUM_COUNTERS-1:0]  hit;
      logic [WIRE_BITS-1:0]     bytes;
   } stat_upd_type;

   typedef struct packed {
      logic                 valid;
      logic [CIDX_BITS-1:0] index;
   } stat_rd_type;

endpackage

### design/eth_ipv4_udp_classifier.sv
// Channel | Direction | Handshake             | Word
// req     | in        | req_valid / req_stall | req_type: frame byte or counter read
// rsp     | out       | rsp_valid / rsp_stall | rsp_type: payload byte, verdict, counter
// csr     | in        | csr_valid / csr_ready | payload_limit, 16 bits
//
// Takes one request word per clock while req_stall is low; a frame byte is parsed in its accept cycle.
// Results pass through a stage register into an 8-word response queue; a
// request that yields two words (payload byte plus verdict) pushes both at once; they leave one by one.
// req_stall rises during the clearing pass, or when queue level plus the words in flight and a new pair would not fit.
// Counters live in two copies of an 8-entry memory fed by a rotating drain of pending increments.
// After reset a clearing pass zeroes the counter memory; csr writes are taken.
module eth_ipv4_udp_classifier
   import euc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic [LENGTH_BITS-1:0]  pos_ff, pos_in;
   logic [15:0]             etype_ff, etype_cur, etype_in;
   logic                    ip_good_ff, ip_good_cur, ip_good_in;
   logic [7:0]              proto_ff, proto_cur, proto_in;
   logic [15:0]             udp_len_ff, udp_len_cur, udp_len_in;
   logic                    trunc_ff, trunc_in;
   logic [WIRE_BITS-1:0]    wire_ff, wire_in;
   logic [LENGTH_BITS-1:0]  sent_ff, sent_cur, sent_in;
   logic [15:0]             limit_ff;

   logic [1:0]              s2_count_ff, s2_count_in;
   logic                    s2_read_ff, s2_read_in;
   rsp_type                 s2_res0_ff, s2_res0_in;
   rsp_type                 s2_res1_ff, s2_res1_in;

   logic                    accept, frame_acc, read_acc, frame_end, start;
   logic                    type_seen, proto_seen, is_ipv4, is_arp, accepted, emit;
   logic [15:0]             room, cap;
   logic [2:0]              verd;
   rsp_type                 res_pay, res_ver, res_cnt, push0;
   stat_upd_type            upd;
   stat_rd_type             rd;
   logic [COUNTER_BITS-1:0] stat_value;
   logic                    stat_busy;
   logic [FIFO_LVL_BITS-1:0] fifo_level;

   assign accept    = req_valid && !req_stall;
   assign frame_acc = accept && (req_data.command == CMD_FRAME);
   assign read_acc  = accept && (req_data.command == CMD_READ);
   assign frame_end = frame_acc && req_data.last_byte;
   assign start     = (pos_ff == '0);

   // header capture, fresh state on the first byte of a frame
   always_comb begin
      trunc_in    = start ? req_data.truncated : trunc_ff;
      wire_in     = start ? req_data.wire_length : wire_ff;
      etype_cur   = start ? 16'd0 : etype_ff;
      ip_good_cur = start ? 1'b0 : ip_good_ff;
      proto_cur   = start ? 8'd0 : proto_ff;
      udp_len_cur = start ? 16'd0 : udp_len_ff;
      sent_cur    = start ? '0 : sent_ff;
      etype_in    = etype_cur;
      ip_good_in  = ip_good_cur;
      proto_in    = proto_cur;
      udp_len_in  = udp_len_cur;
      unique case (pos_ff)
         POS_TYPE_HI: etype_in   = {req_data.frame_byte, etype_cur[7:0]};
         POS_TYPE_LO: etype_in   = {etype_cur[15:8], req_data.frame_byte};
         POS_IP:      ip_good_in = (req_data.frame_byte == IP_VER_IHL);
         POS_PROTO:   proto_in   = req_data.frame_byte;
         POS_ULEN_HI: udp_len_in = {req_data.frame_byte, udp_len_cur[7:0]};
         POS_ULEN_LO: udp_len_in = {udp_len_cur[15:8], req_data.frame_byte};
         default: ;
      endcase
   end

   assign type_seen  = (pos_ff >= POS_TYPE_LO);
   assign proto_seen = (pos_ff >= POS_PROTO);
   assign is_ipv4    = type_seen && (etype_in == TYPE_IPV4);
   assign is_arp     = type_seen && (etype_in == TYPE_ARP);
   assign accepted   = !trunc_in && is_ipv4 && proto_seen && ip_good_in
                    && (proto_in == PROTO_UDP);

   assign room = udp_len_in - UDP_HDR_LEN;
   assign cap  = (room > limit_ff) ? limit_ff : room;
   assign emit = frame_acc && accepted && (pos_ff >= POS_PAYLOAD)
              && (udp_len_in >= UDP_HDR_LEN) && (16'(sent_cur) < cap)
              && (sent_cur != LEN_MAX);
   assign sent_in = sent_cur + LENGTH_BITS'(emit);

   always_comb begin
      if (req_data.last_byte) begin
         pos_in = '0;
      end else if (pos_ff != LEN_MAX) begin
         pos_in = pos_ff + LENGTH_BITS'(1);
      end else begin
         pos_in = pos_ff;
      end
   end

   always_comb begin
      upd.hit   = '0;
      upd.bytes = wire_in;
      verd      = VERD_UNKNOWN;
      if (frame_end) begin
         upd.hit[CNT_TOTAL] = 1'b1;
         upd.hit[CNT_BYTES] = 1'b1;
         priority if (trunc_in) begin
            upd.hit[CNT_TRUNC] = 1'b1;
            verd = VERD_TRUNC;
         end else if (is_arp) begin
            upd.hit[CNT_ARP] = 1'b1;
            verd = VERD_ARP;
         end else if (is_ipv4) begin
            upd.hit[CNT_IPV4] = 1'b1;
            if (accepted) begin
               upd.hit[CNT_UDP] = 1'b1;
               verd = VERD_UDP;
            end else begin
               upd.hit[CNT_IPOTHER] = 1'b1;
               verd = VERD_IPOTHER;
            end
         end else begin
            upd.hit[CNT_UNKNOWN] = 1'b1;
            verd = VERD_UNKNOWN;
         end
      end
   end

   assign rd.valid = read_acc;
   assign rd.index = req_data.counter_index;

   always_comb begin
      res_pay                = '0;
      res_pay.result_kind    = KIND_PAYLOAD;
      res_pay.payload_byte   = req_data.frame_byte;
      res_pay.final_res      = !req_data.last_byte;

      res_ver                = '0;
      res_ver.result_kind    = KIND_VERDICT;
      res_ver.verdict        = verd;
      res_ver.payload_length = (verd == VERD_UDP) ? 16'(sent_in) : 16'd0;
      res_ver.final_res      = 1'b1;

      res_cnt                = '0;
      res_cnt.result_kind    = KIND_COUNTER;
      res_cnt.final_res      = 1'b1;
   end

   always_comb begin
      s2_read_in  = read_acc;
      s2_res1_in  = res_ver;
      s2_res0_in  = emit ? res_pay : res_ver;
      s2_count_in = 2'd0;
      if (read_acc) begin
         s2_res0_in  = res_cnt;
         s2_count_in = 2'd1;
      end else if (frame_acc) begin
         s2_count_in = 2'(emit) + 2'(req_data.last_byte);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         etype_ff    <= '0;
         ip_good_ff  <= 1'b0;
         proto_ff    <= '0;
         udp_len_ff  <= '0;
         trunc_ff    <= 1'b0;
         wire_ff     <= '0;
         sent_ff     <= '0;
         limit_ff    <= 16'hFFFF;
         s2_count_ff <= 2'd0;
         s2_read_ff  <= 1'b0;
      end else begin
         if (frame_acc) begin
            pos_ff     <= pos_in;
            etype_ff   <= etype_in;
            ip_good_ff <= ip_good_in;
            proto_ff   <= proto_in;
            udp_len_ff <= udp_len_in;
            trunc_ff   <= trunc_in;
            wire_ff    <= wire_in;
            sent_ff    <= sent_in;
         end
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
         s2_count_ff <= s2_count_in;
         s2_read_ff  <= s2_read_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_res0_ff <= s2_res0_in;
      s2_res1_ff <= s2_res1_in;
   end

   // fill in the counter value once the memory read returns
   always_comb begin
      push0 = s2_res0_ff;
      if (s2_read_ff) begin
         push0.counter_value = 64'(stat_value);
      end
   end

   assign req_stall = stat_busy
                   || ((FIFO_SUM_BITS'(fifo_level) + FIFO_SUM_BITS'(s2_count_ff))
                       > FIFO_SUM_BITS'(FIFO_DEPTH - 2));
   assign csr_ready = 1'b1;

   euc_stats u_stats (
      .clock      (clock),
      .reset      (reset),
      .upd        (upd),
      .rd         (rd),
      .stat_value (stat_value),
      .busy       (stat_busy)
   );

   euc_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (s2_count_ff),
      .push0      (push0),
      .push1      (s2_res1_ff),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .level      (fifo_level)
   );

`ifndef ASSERT_OFF
   a_frame_end_rewinds: assert property (@(posedge clock) disable iff (reset)
      frame_end |=> pos_ff == '0)
      else $error("byte position not rewound after last byte");

   a_read_single_word: assert property (@(posedge clock) disable iff (reset)
      read_acc |=> s2_read_ff && s2_count_ff == 2'd1)
      else $error("counter read did not yield exactly one word");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      s2_count_ff == 2'd2 |-> s2_res0_ff.result_kind == KIND_PAYLOAD
                            && s2_res1_ff.result_kind == KIND_VERDICT)
      else $error("word pair not payload then verdict");
`endif

endmodule

### design/euc_ram.sv
module euc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### design/euc_stats.sv
module euc_stats
   import euc_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  stat_upd_type            upd,
   input  stat_rd_type             rd,
   output logic [COUNTER_BITS-1:0] stat_value,
   output logic                    busy
);

   // acc_ff[k] holds the pending increment of counter drain_idx_ff + k
   logic [CIDX_BITS-1:0]    drain_idx_ff, drain_idx_in;
   logic [ACC_BITS-1:0]     acc_ff [NUM_COUNTERS];
   logic [ACC_BITS-1:0]     acc_in [NUM_COUNTERS];
   logic [ACC_BITS-1:0]     inc [NUM_COUNTERS];
   logic [ACC_BITS-1:0]     inc_rot [NUM_COUNTERS];
   logic [CIDX_BITS-1:0]    rot_idx [NUM_COUNTERS];
   logic                    wb_valid_ff;
   logic                    wb_clear_ff, wb_clear_in;
   logic [CIDX_BITS-1:0]    wb_idx_ff;
   logic [ACC_BITS-1:0]     wb_add_ff;
   logic                    clear_ff, clear_in;
   logic [EXTRA_BITS-1:0]   extra_ff, extra_in;
   logic [CIDX_BITS-1:0]    rel_idx;
   logic [COUNTER_BITS-1:0] drain_rdata, read_rdata, wb_data;

   always_comb begin
      for (int c = 0; c < NUM_COUNTERS; c++) begin
         if (!upd.hit[c]) begin
            inc[c] = '0;
         end else if (c == int'(CNT_BYTES)) begin
            inc[c] = ACC_BITS'(upd.bytes);
         end else begin
            inc[c] = ACC_BITS'(1);
         end
      end
   end

   // advance the ring by one place: slot 0 drains into the memory
   always_comb begin
      for (int k = 0; k < NUM_COUNTERS; k++) begin
         rot_idx[k] = drain_idx_ff + CIDX_BITS'(k + 1);
         inc_rot[k] = inc[rot_idx[k]];
         if (k == NUM_COUNTERS - 1) begin
            acc_in[k] = inc_rot[k];
         end else begin
            acc_in[k] = acc_ff[(k + 1) % NUM_COUNTERS] + inc_rot[k];
         end
      end
   end

   assign drain_idx_in = drain_idx_ff + CIDX_BITS'(1);
   assign clear_in     = clear_ff && (drain_idx_ff != CIDX_BITS'(NUM_COUNTERS - 1));
   assign wb_clear_in  = clear_ff;

   assign rel_idx  = rd.index - drain_idx_ff;
   assign extra_in = EXTRA_BITS'(acc_ff[rel_idx])
                   + ((wb_valid_ff && (wb_idx_ff == rd.index)) ? EXTRA_BITS'(wb_add_ff)
                                                               : EXTRA_BITS'(0));

   assign wb_data = (wb_clear_ff ? COUNTER_BITS'(0) : drain_rdata)
                  + COUNTER_BITS'(wb_add_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         drain_idx_ff <= '0;
         wb_valid_ff  <= 1'b0;
         wb_clear_ff  <= 1'b0;
         clear_ff     <= 1'b1;
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            acc_ff[k] <= '0;
         end
      end else begin
         drain_idx_ff <= drain_idx_in;
         wb_valid_ff  <= 1'b1;
         wb_clear_ff  <= wb_clear_in;
         clear_ff     <= clear_in;
         for (int k = 0; k < NUM_COUNTERS; k++) begin
            acc_ff[k] <= acc_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      wb_idx_ff <= drain_idx_ff;
      wb_add_ff <= acc_ff[0];
      extra_ff  <= extra_in;
   end

   // two copies of the counter store: one read port drains, the other answers reads
   euc_ram #(
      .WIDTH (COUNTER_BITS),
      .DEPTH (NUM_COUNTERS)
   ) u_ram_drain (
      .clock   (clock),
      .wr_en   (wb_valid_ff),
      .wr_addr (wb_idx_ff),
      .wr_data (wb_data),
      .rd_en   (1'b1),
      .rd_addr (drain_idx_ff),
      .rd_data (drain_rdata)
   );

   euc_ram #(
      .WIDTH (COUNTER_BITS),
      .DEPTH (NUM_COUNTERS)
   ) u_ram_read (
      .clock   (clock),
      .wr_en   (wb_valid_ff),
      .wr_addr (wb_idx_ff),
      .wr_data (wb_data),
      .rd_en   (rd.valid),
      .rd_addr (rd.index),
      .rd_data (read_rdata)
   );

   assign stat_value = read_rdata + COUNTER_BITS'(extra_ff);
   assign busy       = clear_ff || wb_clear_ff;

`ifndef ASSERT_OFF
   a_no_read_while_clearing: assert property (@(posedge clock) disable iff (reset)
      busy |-> !rd.valid)
      else $error("counter read during clearing pass");
`endif

endmodule

### design/euc_rsp_fifo.sv
module euc_rsp_fifo
   import euc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [1:0]               push_count,
   input  rsp_type                  push0,
   input  rsp_type                  push1,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output rsp_type                  rsp_data,
   output logic [FIFO_LVL_BITS-1:0] level
);

   rsp_type                  entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_LVL_BITS-1:0] level_ff, level_in;
   logic [FIFO_PTR_BITS-1:0] wr_ptr_next;
   logic                     pop;

   assign pop         = (level_ff != '0) && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + FIFO_PTR_BITS'(1);
   assign wr_ptr_in   = wr_ptr_ff + FIFO_PTR_BITS'(push_count);
   assign rd_ptr_in   = rd_ptr_ff + FIFO_PTR_BITS'(pop);
   assign level_in    = level_ff + FIFO_LVL_BITS'(push_count) - FIFO_LVL_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push1;
      end
   end

   assign rsp_valid = (level_ff != '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign level     = level_ff;

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (FIFO_SUM_BITS'(level_ff) + FIFO_SUM_BITS'(push_count)) <= FIFO_SUM_BITS'(FIFO_DEPTH))
      else $error("response queue overflow");

   a_push_count_legal: assert property (@(posedge clock) disable iff (reset)
      push_count != 2'd3)
      else $error("more than two words pushed in one cycle");
`endif

endmodule

### sim/euc_frame_checker.sv
module euc_frame_checker
   import euc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_data,
   output int          fail_count,
   output int          pending_count
);

   logic [COUNTER_BITS-1:0] stat_cnt [NUM_COUNTERS];
   logic [LENGTH_BITS-1:0]  byte_pos;
   logic [15:0]             eth_type;
   logic                    ip_hdr_ok;
   logic [7:0]              ip_proto;
   logic [15:0]             udp_len;
   logic                    cap_short;
   logic [WIRE_BITS-1:0]    wlen;
   logic [LENGTH_BITS-1:0]  pay_count;
   logic [15:0]             pay_limit;

   rsp_type rsp_expected[$];

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      if (fail_count < 100)
         $display("mismatch %s: expected %0h got %0h", what, want, got);
      fail_count++;
   endtask

   // Advance the frame parser by one request word and queue the words it yields.
   task automatic classify_word(input req_type w);
      rsp_type                r;
      logic [LENGTH_BITS-1:0] pos;
      logic [15:0]            room;
      logic                   type_seen;
      logic                   proto_seen;
      logic                   accepted;
      verdict_type            verd;
      if (w.command == CMD_READ) begin
         r = '0;
         r.result_kind = KIND_COUNTER;
         r.counter_value = stat_cnt[w.counter_index];
         r.final_res = 1'b1;
         rsp_expected.push_back(r);
      end else begin
         pos = byte_pos;
         if (pos == '0) begin
            cap_short = w.truncated;
            wlen = w.wire_length;
            eth_type = '0;
            ip_hdr_ok = 1'b0;
            ip_proto = '0;
            udp_len = '0;
            pay_count = '0;
         end
         case (pos)
            POS_TYPE_HI: eth_type[15:8] = w.frame_byte;
            POS_TYPE_LO: eth_type[7:0] = w.frame_byte;
            POS_IP:      ip_hdr_ok = (w.frame_byte == IP_VER_IHL);
            POS_PROTO:   ip_proto = w.frame_byte;
            POS_ULEN_HI: udp_len[15:8] = w.frame_byte;
            POS_ULEN_LO: udp_len[7:0] = w.frame_byte;
            default: ;
         endcase
         type_seen = (pos >= POS_TYPE_LO);
         proto_seen = (pos >= POS_PROTO);
         accepted = !cap_short && type_seen && eth_type == TYPE_IPV4 && proto_seen &&
                    ip_hdr_ok && ip_proto == PROTO_UDP;
         if (accepted && pos >= POS_PAYLOAD && udp_len >= UDP_HDR_LEN) begin
            room = udp_len - UDP_HDR_LEN;
            if (room > pay_limit)
               room = pay_limit;
            if (pay_count < room && pay_count < LEN_MAX) begin
               r = '0;
               r.result_kind = KIND_PAYLOAD;
               r.payload_byte = w.frame_byte;
               r.final_res = !w.last_byte;
               rsp_expected.push_back(r);
               pay_count++;
            end
         end
         if (w.last_byte) begin
            stat_cnt[CNT_TOTAL] = stat_cnt[CNT_TOTAL] + COUNTER_BITS'(1);
            stat_cnt[CNT_BYTES] = stat_cnt[CNT_BYTES] + COUNTER_BITS'(wlen);
            if (cap_short) begin
               stat_cnt[CNT_TRUNC] = stat_cnt[CNT_TRUNC] + COUNTER_BITS'(1);
               verd = VERD_TRUNC;
            end else if (type_seen && eth_type == TYPE_ARP) begin
               stat_cnt[CNT_ARP] = stat_cnt[CNT_ARP] + COUNTER_BITS'(1);
               verd = VERD_ARP;
            end else if (type_seen && eth_type == TYPE_IPV4) begin
               stat_cnt[CNT_IPV4] = stat_cnt[CNT_IPV4] + COUNTER_BITS'(1);
               if (accepted) begin
                  stat_cnt[CNT_UDP] = stat_cnt[CNT_UDP] + COUNTER_BITS'(1);
                  verd = VERD_UDP;
               end else begin
                  stat_cnt[CNT_IPOTHER] = stat_cnt[CNT_IPOTHER] + COUNTER_BITS'(1);
                  verd = VERD_IPOTHER;
               end
            end else begin
               stat_cnt[CNT_UNKNOWN] = stat_cnt[CNT_UNKNOWN] + COUNTER_BITS'(1);
               verd = VERD_UNKNOWN;
            end
            r = '0;
            r.result_kind = KIND_VERDICT;
            r.verdict = verd;
            r.payload_length = (verd == VERD_UDP) ? pay_count : '0;
            r.final_res = 1'b1;
            rsp_expected.push_back(r);
            byte_pos = '0;
         end else if (byte_pos < LEN_MAX) begin
            byte_pos++;
         end
      end
   endtask

   task automatic check_word(input rsp_type got);
      rsp_type want;
      if (rsp_expected.size() == 0) begin
         report_mismatch("unexpected word, kind", 64'(0), 64'(got.result_kind));
      end else begin
         want = rsp_expected.pop_front();
         if (got.result_kind !== want.result_kind)
            report_mismatch("result_kind", 64'(want.result_kind), 64'(got.result_kind));
         if (got.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
         if (got.verdict !== want.verdict)
            report_mismatch("verdict", 64'(want.verdict), 64'(got.verdict));
         if (got.payload_length !== want.payload_length)
            report_mismatch("payload_length", 64'(want.payload_length),
                            64'(got.payload_length));
         if (got.counter_value !== want.counter_value)
            report_mismatch("counter_value", want.counter_value, got.counter_value);
         if (got.final_res !== want.final_res)
            report_mismatch("final_res", 64'(want.final_res), 64'(got.final_res));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         foreach (stat_cnt[k]) stat_cnt[k] = '0;
         byte_pos = '0;
         eth_type = '0;
         ip_hdr_ok = 1'b0;
         ip_proto = '0;
         udp_len = '0;
         cap_short = 1'b0;
         wlen = '0;
         pay_count = '0;
         pay_limit = 16'hFFFF;
         fail_count = 0;
         rsp_expected.delete();
      end else begin
         if (csr_valid && csr_ready)
            pay_limit = csr_data;
         if (rsp_valid && !rsp_stall)
            check_word(rsp_data);
         if (req_valid && !req_stall)
            classify_word(req_data);
      end
      pending_count = rsp_expected.size();
   end

endmodule

### sim/tb_eth_ipv4_udp_classifier.sv
module tb_eth_ipv4_udp_classifier;
   import euc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;

   int   fail_count;
   int   pending_count;
   int   words_sent = 0;
   bit   steady = 1'b0;
   logic [7:0] fbytes[$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   eth_ipv4_udp_classifier dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   euc_frame_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Receiver: alternate stall and go stretches.
   initial begin : rsp_side
      int run_left;
      run_left = 0;
      forever begin
         @(posedge clock);
         if (run_left > 0) begin
            run_left--;
         end else if (!rsp_stall && $urandom_range(0, 2) != 0) begin
            rsp_stall <= 1'b1;
            if ($urandom_range(0, 9) != 0)
               run_left = $urandom_range(1, 3);
            else
               run_left = $urandom_range(10, 40);
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 9) == 0)
               run_left = $urandom_range(50, 200);
            else
               run_left = $urandom_range(1, 12);
         end
      end
   end

   // Hold the word until accepted, then maybe drop valid for a gap.
   task automatic send_word(input req_type w);
      int gap;
      int r;
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
      r = $urandom_range(0, 99);
      if (steady || r < 60)
         gap = 0;
      else if (r < 92)
         gap = $urandom_range(1, 3);
      else
         gap = $urandom_range(8, 30);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_read(input logic [2:0] idx);
      req_type w;
      w.command = CMD_READ;
      w.frame_byte = 8'($urandom);
      w.last_byte = 1'($urandom);
      w.truncated = 1'($urandom);
      w.wire_length = 16'($urandom);
      w.counter_index = idx;
      send_word(w);
   endtask

   // Only the truncated and wire_length fields of the first byte count; randomize them elsewhere.
   task automatic send_frame(input logic short_cap, input logic [15:0] wl);
      req_type w;
      int i;
      for (i = 0; i < fbytes.size(); i++) begin
         if ($urandom_range(0, 29) == 0)
            send_read(3'($urandom_range(0, 7)));
         w.command = CMD_FRAME;
         w.frame_byte = fbytes[i];
         w.last_byte = (i == fbytes.size() - 1);
         w.truncated = (i == 0) ? short_cap : 1'($urandom);
         w.wire_length = (i == 0) ? wl : 16'($urandom);
         w.counter_index = 3'($urandom);
         send_word(w);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // UDP frames, some with odd lengths, plus cut, broken, other-protocol, short-capture and noise frames.
   task automatic run_random_phase(input int quota);
      int          start;
      int          kind;
      int          pay;
      int          len;
      int          cut;
      int          r;
      int          i;
      logic [15:0] ulen;
      logic [15:0] wl;
      logic        short_cap;
      start = words_sent;
      while (words_sent - start < quota) begin
         steady = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 4) == 0)
            send_read(3'($urandom_range(0, 7)));
         kind = $urandom_range(0, 99);
         pay = $urandom_range(0, 16);
         len = 42 + pay + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
         ulen = 16'(8 + pay);
         r = $urandom_range(0, 9);
         if (r < 2)
            ulen = 16'(8 + $urandom_range(0, pay));
         else if (r < 4)
            ulen = 16'(8 + pay + $urandom_range(1, 40));
         else if (r == 4)
            ulen = 16'($urandom);
         fbytes.delete();
         for (i = 0; i < len; i++) fbytes.push_back(8'($urandom));
         fbytes[12] = TYPE_IPV4[15:8];
         fbytes[13] = TYPE_IPV4[7:0];
         fbytes[14] = IP_VER_IHL;
         fbytes[23] = PROTO_UDP;
         fbytes[38] = ulen[15:8];
         fbytes[39] = ulen[7:0];
         short_cap = 1'b0;
         if (kind < 45) begin
         end else if (kind < 50) begin
            fbytes[38] = 8'h00;
            fbytes[39] = 8'($urandom_range(0, 7));
         end else if (kind < 60) begin
            cut = $urandom_range(14, fbytes.size());
            while (fbytes.size() > cut) void'(fbytes.pop_back());
         end else if (kind < 70) begin
            if ($urandom_range(0, 1) == 0)
               fbytes[14] = 8'($urandom);
            else
               fbytes[23] = 8'($urandom);
         end else if (kind < 78) begin
            fbytes[12] = TYPE_ARP[15:8];
            fbytes[13] = TYPE_ARP[7:0];
            cut = $urandom_range(14, fbytes.size());
            while (fbytes.size() > cut) void'(fbytes.pop_back());
         end else if (kind < 86) begin
            fbytes[12] = 8'($urandom);
            fbytes[13] = 8'($urandom);
            cut = $urandom_range(1, fbytes.size());
            while (fbytes.size() > cut) void'(fbytes.pop_back());
         end else if (kind < 95) begin
            short_cap = 1'b1;
         end else begin
            for (i = 0; i < 42; i++) fbytes[i] = 8'($urandom);
            cut = $urandom_range(1, fbytes.size());
            while (fbytes.size() > cut) void'(fbytes.pop_back());
         end
         r = $urandom_range(0, 9);
         wl = (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
         send_frame(short_cap, wl);
      end
      steady = 1'b0;
   endtask

   initial begin : stimulus
      logic [15:0] limits [5];
      int          i;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // counters right after reset, one-byte frames, then a minimal ARP frame
      for (i = 0; i < NUM_COUNTERS; i++) send_read(3'(i));
      fbytes.delete();
      fbytes.push_back(8'hFF);
      send_frame(1'b1, 16'hFFFF);
      fbytes.delete();
      fbytes.push_back(8'h00);
      send_frame(1'b0, 16'h0000);
      fbytes.delete();
      for (i = 0; i < 14; i++) fbytes.push_back(8'($urandom));
      fbytes[12] = TYPE_ARP[15:8];
      fbytes[13] = TYPE_ARP[7:0];
      send_frame(1'b0, 16'd60);

      // hold off until every word has drained
      wait_idle();
      run_random_phase(130);

      limits[0] = 16'h0000;
      limits[1] = 16'd3;
      limits[2] = 16'($urandom_range(1, 20));
      limits[3] = 16'hFFFF;
      limits[4] = 16'($urandom);
      for (i = 0; i < 4; i++) begin
         wait_idle();
         write_limit(limits[i]);
         run_random_phase(130);
      end

      // last limit, then read back every counter
      wait_idle();
      write_limit(limits[4]);
      run_random_phase(40);
      for (i = 0; i < NUM_COUNTERS; i++) send_read(3'(i));

      wait_idle();
      if (fail_count == 0 && pending_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin : watchdog
      #40000000;
      $display("Some tests failed");
      $finish;
   end

endmodule

### sim.f
design/euc_pkg.sv
design/euc_ram.sv
design/euc_stats.sv
design/euc_rsp_fifo.sv
design/eth_ipv4_udp_classifier.sv
sim/euc_frame_checker.sv
sim/tb_eth_ipv4_udp_classifier.sv
